[sv/ffa_pkg.sv]
// shared constants, codes and types of the first-fit free-list allocator
`timescale 1ns / 1ps
package ffa_pkg;

    // arena geometry
    localparam int ARENA_UNITS = 4096;
    localparam int GROW_UNITS  = 1024;
    localparam int UNIT_BYTES  = 16;
    localparam int ADDR_W      = $clog2(ARENA_UNITS);
    localparam int BYTES_W     = 16;
    localparam int SUM_W       = BYTES_W + 1;
    localparam int NEED_W      = ADDR_W + 1;
    localparam int BRK_W       = ADDR_W + 1;
    localparam int SCAN_LIMIT  = 4 * ARENA_UNITS + 8;
    localparam int GUARD_W     = $clog2(SCAN_LIMIT + 1);

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_A_ROOT,
        S_A_FIRST,
        S_A_SCAN,
        S_A_TOP,
        S_R_ROOT,
        S_R_WALK,
        S_M_HDR,
        S_M_NEXT,
        S_M_HI,
        S_M_PREV,
        S_M_HDR2,
        S_M_LO,
        S_FREED
    } t_state;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INIT,
        OP_A_ROOT,
        OP_A_FIRST,
        OP_A_EXACT,
        OP_A_CARVE,
        OP_A_TOP,
        OP_A_NEXT,
        OP_GROW,
        OP_OOM,
        OP_R_ROOT,
        OP_R_NEXT,
        OP_R_STOP,
        OP_M_HDR,
        OP_M_NEXT,
        OP_M_HI,
        OP_M_PREV,
        OP_M_HDR2,
        OP_M_LO,
        OP_FREED
    } t_op;

    // datapath status toward the controller
    typedef struct packed {
        logic started;
        logic kind;
        logic guard_hit;
        logic fits;
        logic exact;
        logic at_rover;
        logic grow_ok;
        logic walk_stop;
    } t_stat;

endpackage

[sv/ffa_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module ffa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

[sv/ffa_ctrl.sv]
// controller state machine of the allocator
`timescale 1ns / 1ps
module ffa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ffa_pkg::t_stat i_stat,
    output ffa_pkg::t_op  o_op,
    output logic          busy
);
    import ffa_pkg::*;

    t_state r_state, n_state;
    logic   r_ret_alloc, n_ret_alloc;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret_alloc <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret_alloc <= n_ret_alloc;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_ret_alloc = r_ret_alloc;
        o_op        = OP_NONE;
        busy        = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_op = i_stat.started ? OP_NONE : OP_INIT;
                if (i_stat.kind == KIND_ALLOC) begin
                    n_state = S_A_ROOT;
                end else begin
                    n_ret_alloc = 1'b0;
                    n_state     = S_R_ROOT;
                end
            end
            S_A_ROOT: begin
                o_op    = OP_A_ROOT;
                n_state = S_A_FIRST;
            end
            S_A_FIRST: begin
                o_op    = OP_A_FIRST;
                n_state = S_A_SCAN;
            end
            // one free-list node per cycle
            S_A_SCAN: begin
                priority if (i_stat.guard_hit) begin
                    o_op    = OP_OOM;
                    n_state = S_IDLE;
                end else if (i_stat.exact) begin
                    o_op    = OP_A_EXACT;
                    n_state = S_IDLE;
                end else if (i_stat.fits) begin
                    o_op    = OP_A_CARVE;
                    n_state = S_A_TOP;
                end else if (i_stat.at_rover) begin
                    if (i_stat.grow_ok) begin
                        o_op        = OP_GROW;
                        n_ret_alloc = 1'b1;
                        n_state     = S_R_ROOT;
                    end else begin
                        o_op    = OP_OOM;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_op = OP_A_NEXT;
                end
            end
            S_A_TOP: begin
                o_op    = OP_A_TOP;
                n_state = S_IDLE;
            end
            S_R_ROOT: begin
                o_op    = OP_R_ROOT;
                n_state = S_R_WALK;
            end
            // walk to the insertion point
            S_R_WALK: begin
                if (i_stat.walk_stop) begin
                    o_op    = OP_R_STOP;
                    n_state = S_M_HDR;
                end else begin
                    o_op = OP_R_NEXT;
                end
            end
            S_M_HDR: begin
                o_op    = OP_M_HDR;
                n_state = S_M_NEXT;
            end
            S_M_NEXT: begin
                o_op    = OP_M_NEXT;
                n_state = S_M_HI;
            end
            S_M_HI: begin
                o_op    = OP_M_HI;
                n_state = S_M_PREV;
            end
            S_M_PREV: begin
                o_op    = OP_M_PREV;
                n_state = S_M_HDR2;
            end
            S_M_HDR2: begin
                o_op    = OP_M_HDR2;
                n_state = S_M_LO;
            end
            S_M_LO: begin
                o_op    = OP_M_LO;
                n_state = r_ret_alloc ? S_A_ROOT : S_FREED;
            end
            S_FREED: begin
                o_op    = OP_FREED;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/ffa_dp.sv]
// datapath of the allocator: header stores, pointers and result register
`timescale 1ns / 1ps
module ffa_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffa_pkg::t_op                i_op,
    input  logic                        i_kind,
    input  logic [ffa_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]  i_block_address,
    output ffa_pkg::t_stat              o_stat,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [ffa_pkg::ADDR_W-1:0]  o_payload_address
);
    import ffa_pkg::*;

    logic               r_kind, n_kind;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [ADDR_W-1:0]  r_hdr, n_hdr;
    logic [ADDR_W-1:0]  r_p, n_p;
    logic [ADDR_W-1:0]  r_prev, n_prev;
    logic [ADDR_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0]  r_q, n_q;
    logic [ADDR_W-1:0]  r_rover, n_rover;
    logic [BRK_W-1:0]   r_brk, n_brk;
    logic               r_started, n_started;
    logic [GUARD_W-1:0] r_aguard, n_aguard;
    logic [GUARD_W-1:0] r_rguard, n_rguard;
    logic [ADDR_W-1:0]  r_size_hdr, n_size_hdr;
    logic [ADDR_W-1:0]  r_size_p, n_size_p;
    logic               r_valid, n_valid;
    logic [1:0]         r_status, n_status;
    logic [ADDR_W-1:0]  r_paddr, n_paddr;

    logic [ADDR_W-1:0]  rd_link, rd_size, rd_addr, wr_addr, link_wd, size_wd;
    logic               link_we, size_we;
    logic [NEED_W-1:0]  amount;
    logic [BRK_W:0]     brk_end;
    logic [ADDR_W-1:0]  carve_size;
    logic               join_hi, join_lo;

    // header stores
    ffa_ram #(.WIDTH(ADDR_W), .DEPTH(ARENA_UNITS)) u_link_ram (
        .i_clk     (i_clk),
        .i_we      (link_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (link_wd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_link)
    );

    ffa_ram #(.WIDTH(ADDR_W), .DEPTH(ARENA_UNITS)) u_size_ram (
        .i_clk     (i_clk),
        .i_we      (size_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (size_wd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_size)
    );

    // status toward the controller
    assign amount  = (r_need < NEED_W'(GROW_UNITS)) ? NEED_W'(GROW_UNITS) : r_need;
    assign brk_end = {1'b0, r_brk} + (BRK_W + 1)'(amount);
    assign carve_size = rd_size - r_need[ADDR_W-1:0];
    assign join_hi = (({1'b0, r_hdr} + {1'b0, r_size_hdr}) == {1'b0, r_n});
    assign join_lo = (({1'b0, r_p} + {1'b0, r_size_p}) == {1'b0, r_hdr});

    always_comb begin
        o_stat.started   = r_started;
        o_stat.kind      = r_kind;
        o_stat.guard_hit = (r_aguard == GUARD_W'(SCAN_LIMIT));
        o_stat.fits      = ({1'b0, rd_size} >= r_need);
        o_stat.exact     = ({1'b0, rd_size} == r_need);
        o_stat.at_rover  = (r_p == r_rover);
        o_stat.grow_ok   = (r_brk < BRK_W'(ARENA_UNITS))
                           && (brk_end <= (BRK_W + 1)'(ARENA_UNITS));
        o_stat.walk_stop = ((r_hdr > r_p) && (r_hdr < rd_link))
                           || ((r_p >= rd_link) && ((r_hdr > r_p) || (r_hdr < rd_link)))
                           || (r_rguard == GUARD_W'(SCAN_LIMIT - 1));
    end

    // command decode
    always_comb begin
        n_kind     = r_kind;
        n_need     = r_need;
        n_hdr      = r_hdr;
        n_p        = r_p;
        n_prev     = r_prev;
        n_n        = r_n;
        n_q        = r_q;
        n_rover    = r_rover;
        n_brk      = r_brk;
        n_started  = r_started;
        n_aguard   = r_aguard;
        n_rguard   = r_rguard;
        n_size_hdr = r_size_hdr;
        n_size_p   = r_size_p;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_paddr    = r_paddr;
        rd_addr    = r_rover;
        wr_addr    = r_p;
        link_we    = 1'b0;
        size_we    = 1'b0;
        link_wd    = rd_link;
        size_wd    = rd_size;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_ACCEPT: begin
                n_kind   = i_kind;
                n_need   = NEED_W'(({1'b0, i_request_bytes} + SUM_W'(UNIT_BYTES - 1))
                           / UNIT_BYTES) + NEED_W'(1);
                n_hdr    = i_block_address - ADDR_W'(1);
                n_aguard = '0;
            end
            // sentinel at unit zero
            OP_INIT: begin
                wr_addr   = '0;
                link_we   = 1'b1;
                size_we   = 1'b1;
                link_wd   = '0;
                size_wd   = '0;
                n_rover   = '0;
                n_started = 1'b1;
            end
            OP_A_ROOT: begin
                rd_addr = r_rover;
                n_prev  = r_rover;
            end
            OP_A_FIRST: begin
                n_p     = rd_link;
                rd_addr = rd_link;
            end
            // exact fit: unlink the block
            OP_A_EXACT: begin
                wr_addr  = r_prev;
                link_we  = 1'b1;
                link_wd  = rd_link;
                n_rover  = r_prev;
                n_valid  = 1'b1;
                n_status = ST_ALLOC;
                n_paddr  = r_p + ADDR_W'(1);
            end
            // larger block: shrink it, hand out its top end
            OP_A_CARVE: begin
                wr_addr = r_p;
                size_we = 1'b1;
                size_wd = carve_size;
                n_q     = r_p + carve_size;
                n_rover = r_prev;
            end
            OP_A_TOP: begin
                wr_addr  = r_q;
                size_we  = 1'b1;
                size_wd  = r_need[ADDR_W-1:0];
                n_valid  = 1'b1;
                n_status = ST_ALLOC;
                n_paddr  = r_q + ADDR_W'(1);
            end
            OP_A_NEXT: begin
                n_prev   = r_p;
                n_p      = rd_link;
                rd_addr  = rd_link;
                n_aguard = r_aguard + GUARD_W'(1);
            end
            // claim fresh units at the break
            OP_GROW: begin
                wr_addr  = r_brk[ADDR_W-1:0];
                size_we  = 1'b1;
                size_wd  = amount[ADDR_W-1:0];
                n_brk    = brk_end[BRK_W-1:0];
                n_hdr    = r_brk[ADDR_W-1:0];
                n_aguard = r_aguard + GUARD_W'(1);
            end
            OP_OOM: begin
                n_valid  = 1'b1;
                n_status = ST_OOM;
                n_paddr  = '0;
            end
            OP_R_ROOT: begin
                rd_addr  = r_rover;
                n_p      = r_rover;
                n_rguard = '0;
            end
            OP_R_NEXT: begin
                n_p      = rd_link;
                rd_addr  = rd_link;
                n_rguard = r_rguard + GUARD_W'(1);
            end
            OP_R_STOP: begin
                n_n = rd_link;
            end
            OP_M_HDR: begin
                rd_addr = r_hdr;
            end
            OP_M_NEXT: begin
                n_size_hdr = rd_size;
                rd_addr    = r_n;
            end
            // merge with the upper neighbor
            OP_M_HI: begin
                wr_addr = r_hdr;
                link_we = 1'b1;
                if (join_hi) begin
                    size_we = 1'b1;
                    size_wd = r_size_hdr + rd_size;
                    link_wd = rd_link;
                end else begin
                    link_wd = r_n;
                end
            end
            OP_M_PREV: begin
                rd_addr = r_p;
            end
            OP_M_HDR2: begin
                n_size_p = rd_size;
                rd_addr  = r_hdr;
            end
            // merge with the lower neighbor
            OP_M_LO: begin
                wr_addr = r_p;
                link_we = 1'b1;
                if (join_lo) begin
                    size_we = 1'b1;
                    size_wd = r_size_p + rd_size;
                    link_wd = rd_link;
                end else begin
                    link_wd = r_hdr;
                end
                n_rover = r_p;
            end
            OP_FREED: begin
                n_valid  = 1'b1;
                n_status = ST_FREED;
                n_paddr  = '0;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover   <= '0;
            r_brk     <= BRK_W'(1);
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_rover   <= n_rover;
            r_brk     <= n_brk;
            r_started <= n_started;
            r_valid   <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_need     <= n_need;
        r_hdr      <= n_hdr;
        r_p        <= n_p;
        r_prev     <= n_prev;
        r_n        <= n_n;
        r_q        <= n_q;
        r_aguard   <= n_aguard;
        r_rguard   <= n_rguard;
        r_size_hdr <= n_size_hdr;
        r_size_p   <= n_size_p;
        r_status   <= n_status;
        r_paddr    <= n_paddr;
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_payload_address = r_paddr;

endmodule

[sv/first_fit_free_list_allocator.sv]
// top level of the first-fit free-list allocator
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_valid, and the receiver cannot stall it.
// Every step reads the header stores, one port each, so one free-list node is
// visited per cycle. An allocate passes through the accept, setup, the root and
// first reads, one scan step per node, one more step when a block is split, and
// for each arena growth a growth step, the insertion walk and the merge steps;
// a free passes through the accept, setup, the root read, the walk to the
// insertion point, the merge steps and the result. The time a request takes thus follows the free-list length.
module first_fit_free_list_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic [ffa_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [ffa_pkg::ADDR_W-1:0]  i_block_address,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [ffa_pkg::ADDR_W-1:0]  o_payload_address
);
    import ffa_pkg::*;

    t_op   op;
    t_stat stat;

    // sequencer
    ffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_op    (op),
        .busy    (busy)
    );

    // pointers and header stores
    ffa_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .i_kind            (i_kind),
        .i_request_bytes   (i_request_bytes),
        .i_block_address   (i_block_address),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_payload_address (o_payload_address)
    );

    // a result only appears once the request is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // only allocations carry an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_ALLOC)) |-> (o_payload_address == '0))
        else $error("address on a non-allocation result");

    // no result without a prior request
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

endmodule
